// ===== src/assert_macros.svh =====
// Assertion macros shared by the direction map cost table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while the block is out of reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/dmct_pkg.sv =====
// Shared types and constants of the direction map cost table.
package dmct_pkg;

  // Default geometry and number format.
  localparam int unsigned COORD_BITS_DEF = 8;
  localparam int unsigned FRAC_BITS_DEF  = 14;

  // Fixed field widths.
  localparam int unsigned COORD_W = 8;
  localparam int unsigned COST_W  = 24;
  localparam int unsigned OLD_W   = 9;
  localparam int unsigned MIS_W   = 16;

  // Configuration port.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [OLD_W-1:0] OLD_WEIGHT_RST = 9'd179;
  localparam logic [MIS_W-1:0] MIS_WEIGHT_RST = 16'd256;
  localparam logic [OLD_W-1:0] KEEP_FULL      = 9'd256;

  // sqrt(2) with 52 fraction bits.
  localparam logic [63:0] ROOT2_Q52 = 64'h0016_A09E_667F_3BCD;

  typedef enum logic [0:0] {
    CMD_RECORD = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_OLD_WEIGHT      = 1'b0,
    REG_MISMATCH_WEIGHT = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_TO,
    ST_WR_FROM,
    ST_MISM,
    ST_MUL,
    ST_FIN
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic wr_to;
    logic wr_from;
    logic mism;
    logic mul;
    logic fin;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_query;
    logic same_cell;
    logic clr_last;
  } dp_sts_t;

endpackage

// ===== src/dmct_regs.sv =====
// Configuration registers behind the APB-style port.
module dmct_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dmct_pkg::APB_AW-1:0]      paddr,
  input  logic [dmct_pkg::APB_DW-1:0]      pwdata,
  output logic [dmct_pkg::APB_DW-1:0]      prdata,
  output logic                             pready,
  output logic [dmct_pkg::OLD_W-1:0]       old_weight_o,
  output logic [dmct_pkg::MIS_W-1:0]       mismatch_weight_o
);

  logic                         wr_en;
  dmct_pkg::reg_e               reg_idx;
  logic [dmct_pkg::OLD_W-1:0]   old_weight_q;
  logic [dmct_pkg::MIS_W-1:0]   mismatch_weight_q;

  // Registers are word aligned; the word index picks the register.
  assign reg_idx = dmct_pkg::reg_e'(paddr[dmct_pkg::APB_AW-1]);
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  // Register writes on the access cycle of a write transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_weight_q      <= dmct_pkg::OLD_WEIGHT_RST;
      mismatch_weight_q <= dmct_pkg::MIS_WEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        dmct_pkg::REG_OLD_WEIGHT: begin
          old_weight_q <= pwdata[dmct_pkg::OLD_W-1:0];
        end
        dmct_pkg::REG_MISMATCH_WEIGHT: begin
          mismatch_weight_q <= pwdata[dmct_pkg::MIS_W-1:0];
        end
        default: begin
          old_weight_q <= old_weight_q;
        end
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_idx)
      dmct_pkg::REG_OLD_WEIGHT:      prdata = dmct_pkg::APB_DW'(old_weight_q);
      dmct_pkg::REG_MISMATCH_WEIGHT: prdata = dmct_pkg::APB_DW'(mismatch_weight_q);
      default:                       prdata = '0;
    endcase
  end

  assign old_weight_o      = old_weight_q;
  assign mismatch_weight_o = mismatch_weight_q;

endmodule

// ===== src/dmct_ctrl.sv =====
// Controller state machine: clearing pass, item sequencing and busy flag.
`include "assert_macros.svh"

module dmct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dmct_pkg::dp_sts_t sts_i,
  output dmct_pkg::dp_cmd_t cmd_o
);

  dmct_pkg::state_e state_q, state_d;

  // State register; reset starts the clearing pass over the seen bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmct_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      dmct_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = dmct_pkg::ST_IDLE;
        end
      end
      dmct_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          if (sts_i.is_query) begin
            state_d = dmct_pkg::ST_MISM;
          end else if (!sts_i.same_cell) begin
            state_d = dmct_pkg::ST_WR_TO;
          end
        end
      end
      dmct_pkg::ST_WR_TO: begin
        cmd_o.wr_to = 1'b1;
        state_d     = dmct_pkg::ST_WR_FROM;
      end
      dmct_pkg::ST_WR_FROM: begin
        cmd_o.wr_from = 1'b1;
        state_d       = dmct_pkg::ST_IDLE;
      end
      dmct_pkg::ST_MISM: begin
        cmd_o.mism = 1'b1;
        state_d    = dmct_pkg::ST_MUL;
      end
      dmct_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = dmct_pkg::ST_FIN;
      end
      dmct_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = dmct_pkg::ST_IDLE;
      end
      default: begin
        state_d = dmct_pkg::ST_IDLE;
      end
    endcase
  end

  // The clearing pass ends only after the last table entry is written.
  `ASSERT_RST(a_clear_ends_at_last, (state_q == dmct_pkg::ST_CLEAR && state_d != dmct_pkg::ST_CLEAR) |-> sts_i.clr_last, "clearing pass ended early")
  // A query transfer always runs through to its finishing cycle.
  `ASSERT_RST(a_query_reaches_fin, (cmd_o.load && sts_i.is_query) |=> ##2 cmd_o.fin, "query did not finish in sequence")
  // A record of two different cells writes the to cell and then the from cell.
  `ASSERT_RST(a_record_writes_both, cmd_o.wr_to |=> cmd_o.wr_from, "record wrote only one cell")

endmodule

// ===== src/dmct_dpath.sv =====
// Datapath: direction table memory, blend unit, cost arithmetic and result register.
`include "assert_macros.svh"

module dmct_dpath #(
  parameter int unsigned COORD_BITS = dmct_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dmct_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              command_i,
  input  logic [dmct_pkg::COORD_W-1:0]      from_x_i,
  input  logic [dmct_pkg::COORD_W-1:0]      from_y_i,
  input  logic [dmct_pkg::COORD_W-1:0]      to_x_i,
  input  logic [dmct_pkg::COORD_W-1:0]      to_y_i,
  input  logic [dmct_pkg::OLD_W-1:0]        old_weight_i,
  input  logic [dmct_pkg::MIS_W-1:0]        mismatch_weight_i,
  input  dmct_pkg::dp_cmd_t                 cmd_i,
  output dmct_pkg::dp_sts_t                 sts_o,
  output logic signed [dmct_pkg::COST_W-1:0] cost_o,
  output logic                              reachable_o,
  output logic                              done_o
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned AW    = 2 * COORD_BITS;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned VW    = FRAC_BITS + 2;        // Q2.F vector component
  localparam int unsigned DW    = 2 * VW + 1;           // seen bit, x, y
  localparam int unsigned BW    = FRAC_BITS + 12;       // blend sum
  localparam int unsigned MW    = FRAC_BITS + 4;        // mismatch sum
  localparam int unsigned PW    = dmct_pkg::MIS_W + 1 + MW;
  localparam int unsigned RW    = PW - 10;
  localparam int unsigned SW    = ((RW + 1 > dmct_pkg::COST_W) ? RW + 1 : dmct_pkg::COST_W) + 1;

  localparam logic signed [CW:0]   D_ONE   = (CW + 1)'(1);
  localparam logic signed [VW-1:0] ONE_V   = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [VW-1:0] ZERO_V  = '0;
  localparam logic signed [MW-1:0] ONE_M   = MW'(ONE_V);
  localparam logic signed [MW-1:0] ZERO_M  = '0;
  localparam logic signed [BW-1:0] HALF_B  = BW'(128);
  localparam logic signed [BW-1:0] HALF_BM = BW'(127);
  localparam logic signed [BW-1:0] ZERO_B  = '0;
  localparam logic signed [PW-1:0] HALF_P  = PW'(512);
  localparam logic signed [PW-1:0] HALF_PM = PW'(511);
  localparam logic [63:0]          H64     =
      (dmct_pkg::ROOT2_Q52 + (64'd1 << (51 - FRAC_BITS))) >> (52 - FRAC_BITS);
  localparam logic signed [SW-1:0] H_DIAG  = SW'(H64);
  localparam logic signed [SW-1:0] H_ONE   = SW'(ONE_V);
  localparam logic signed [SW-1:0] H_ZERO  = '0;
  localparam logic signed [SW-1:0] C_MAX   = SW'(2 ** (dmct_pkg::COST_W - 1) - 1);
  localparam logic signed [SW-1:0] C_MIN   = ~C_MAX;
  localparam logic signed [1:0]    S_POS   = 2'sd1;
  localparam logic signed [1:0]    S_NEG   = -2'sd1;

  // One blended vector component, rounded to nearest with ties away from zero.
  function automatic logic signed [VW-1:0] blend_comp(
    input logic signed [VW-1:0]          s,
    input logic signed [1:0]             sg,
    input logic [dmct_pkg::OLD_W-1:0]    kp,
    input logic [dmct_pkg::OLD_W-1:0]    fr
  );
    logic signed [BW-1:0] prod;
    logic signed [BW-1:0] frs;
    logic signed [BW-1:0] sum;
    logic signed [BW-1:0] rnd;
    prod = BW'(s) * BW'($signed({1'b0, kp}));
    frs  = BW'($signed({1'b0, fr})) <<< FRAC_BITS;
    if (sg == S_NEG) begin
      frs = -frs;
    end else if (sg != S_POS) begin
      frs = ZERO_B;
    end
    sum = prod + frs;
    rnd = (sum + (sum[BW-1] ? HALF_BM : HALF_B)) >>> 8;
    return rnd[VW-1:0];
  endfunction

  // Disagreement of one stored vector with the step direction; zero if unseen.
  function automatic logic signed [MW-1:0] mismatch(
    input logic [DW-1:0]     w,
    input logic signed [1:0] sgx,
    input logic signed [1:0] sgy
  );
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [MW-1:0] px;
    logic signed [MW-1:0] py;
    vx = w[2*VW-1:VW];
    vy = w[VW-1:0];
    px = (sgx == S_POS) ? MW'(vx) : ((sgx == S_NEG) ? -MW'(vx) : ZERO_M);
    py = (sgy == S_POS) ? MW'(vy) : ((sgy == S_NEG) ? -MW'(vy) : ZERO_M);
    return w[DW-1] ? (ONE_M - px - py) : ZERO_M;
  endfunction

  logic [CW-1:0]        fx, fy, tx, ty;
  logic signed [CW:0]   ddx, ddy;
  logic signed [1:0]    sx, sy;
  logic                 far;
  logic [AW-1:0]        from_idx, to_idx;

  logic [AW-1:0]        from_idx_q, to_idx_q;
  logic signed [1:0]    sx_q, sy_q;
  logic                 reach_q;
  logic [DW-1:0]        rd_from_q, rd_to_q;
  logic [AW-1:0]        clr_cnt_q;
  logic [DW-1:0]        mem_q [DEPTH];

  logic [dmct_pkg::OLD_W-1:0] keep, fresh;
  logic [DW-1:0]        cur;
  logic signed [VW-1:0] ux, uy;
  logic [DW-1:0]        blend_word;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DW-1:0]        wr_data;

  logic signed [MW-1:0] acc_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] rnd_full;
  logic signed [RW-1:0] rnd_r;
  logic signed [SW-1:0] h_val, tot, sat;

  logic signed [dmct_pkg::COST_W-1:0] cost_q;
  logic                 reach_out_q;
  logic                 done_q;

  // Cell coordinates and step direction of the item on the input ports.
  assign fx       = CW'(from_x_i);
  assign fy       = CW'(from_y_i);
  assign tx       = CW'(to_x_i);
  assign ty       = CW'(to_y_i);
  assign ddx      = $signed({1'b0, tx}) - $signed({1'b0, fx});
  assign ddy      = $signed({1'b0, ty}) - $signed({1'b0, fy});
  assign sx       = (ddx > 0) ? S_POS : ((ddx < 0) ? S_NEG : 2'sd0);
  assign sy       = (ddy > 0) ? S_POS : ((ddy < 0) ? S_NEG : 2'sd0);
  assign far      = (ddx > D_ONE) || (ddx < -D_ONE) || (ddy > D_ONE) || (ddy < -D_ONE);
  assign from_idx = {fy, fx};
  assign to_idx   = {ty, tx};

  assign sts_o.is_query  = (command_i == dmct_pkg::CMD_QUERY);
  assign sts_o.same_cell = (from_idx == to_idx);
  assign sts_o.clr_last  = &clr_cnt_q;

  // Item capture on the transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      from_idx_q <= from_idx;
      to_idx_q   <= to_idx;
      sx_q       <= sx;
      sy_q       <= sy;
      reach_q    <= ~far;
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // Blend unit, shared by the two cell writes of a record.
  assign keep  = (old_weight_i > dmct_pkg::KEEP_FULL) ? dmct_pkg::KEEP_FULL : old_weight_i;
  assign fresh = dmct_pkg::KEEP_FULL - keep;
  assign cur   = cmd_i.wr_to ? rd_to_q : rd_from_q;
  assign ux    = (sx_q == S_POS) ? ONE_V : ((sx_q == S_NEG) ? -ONE_V : ZERO_V);
  assign uy    = (sy_q == S_POS) ? ONE_V : ((sy_q == S_NEG) ? -ONE_V : ZERO_V);

  always_comb begin
    if (cur[DW-1]) begin
      blend_word = {1'b1,
                    blend_comp(cur[2*VW-1:VW], sx_q, keep, fresh),
                    blend_comp(cur[VW-1:0], sy_q, keep, fresh)};
    end else begin
      blend_word = {1'b1, ux, uy};
    end
  end

  // Memory write port: clearing pass or one of the two record writes.
  assign wr_en   = cmd_i.clr_wr | cmd_i.wr_to | cmd_i.wr_from;
  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : (cmd_i.wr_to ? to_idx_q : from_idx_q);
  assign wr_data = cmd_i.clr_wr ? '0 : blend_word;

  // Direction table with seen bits; both cells are read on the transfer.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.load) begin
      rd_from_q <= mem_q[from_idx];
      rd_to_q   <= mem_q[to_idx];
    end
  end

  // Query arithmetic: mismatch sum, then weight product.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mism) begin
      acc_q <= mismatch(rd_from_q, sx_q, sy_q) + mismatch(rd_to_q, sx_q, sy_q);
    end
    if (cmd_i.mul) begin
      prod_q <= PW'($signed({1'b0, mismatch_weight_i})) * PW'(acc_q);
    end
  end

  // Round the penalty, add the step length and saturate.
  assign rnd_full = (prod_q + (prod_q[PW-1] ? HALF_PM : HALF_P)) >>> 10;
  assign rnd_r    = rnd_full[RW-1:0];

  always_comb begin
    if (sx_q != 2'sd0 && sy_q != 2'sd0) begin
      h_val = H_DIAG;
    end else if (sx_q != 2'sd0 || sy_q != 2'sd0) begin
      h_val = H_ONE;
    end else begin
      h_val = H_ZERO;
    end
    tot = SW'(rnd_r) + h_val;
    if (tot > C_MAX) begin
      sat = C_MAX;
    end else if (tot < C_MIN) begin
      sat = C_MIN;
    end else begin
      sat = tot;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      cost_q      <= reach_q ? sat[dmct_pkg::COST_W-1:0] : '0;
      reach_out_q <= reach_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.fin;
    end
  end

  assign cost_o      = cost_q;
  assign reachable_o = reach_out_q;
  assign done_o      = done_q;

  // At most one datapath command is active in any cycle.
  `ASSERT_ALWAYS(a_cmd_onehot0, $onehot0({cmd_i.load, cmd_i.clr_wr, cmd_i.wr_to, cmd_i.wr_from, cmd_i.mism, cmd_i.mul, cmd_i.fin}), "overlapping datapath commands")
  // An unreachable result carries a zero cost.
  `ASSERT_RST(a_unreach_zero, (done_o && !reachable_o) |-> (cost_o == '0), "unreachable result with nonzero cost")
  // The result strobe follows the finishing cycle.
  `ASSERT_RST(a_done_after_fin, done_o |-> $past(cmd_i.fin), "result strobe without a finishing cycle")

endmodule

// ===== src/direction_map_cost_table_core.sv =====
// Top level of the direction map cost table: registers, controller and datapath.
//
// After reset the block clears the seen bit of every cell, one cell per clock,
// over all 2^(2*COORD_BITS) cells (65536 with the default grid); busy stays
// high until that pass is done, while configuration writes are taken as usual.
// An item is transferred at a rising edge with start high and busy low. A
// record reads both cells from the table on the transfer, then writes the to
// cell and then the from cell through the single write port; a record of equal
// cells writes nothing and busy stays low. A query runs through table read,
// mismatch sum, weight multiply and final rounding with saturation; its result
// appears on done_o, cost_o and reachable_o for exactly one cycle right after
// the last of these, while the next item may already be transferred. The
// result cannot be held off, so the receiver must take it in that cycle.
// Records produce no result.
module direction_map_cost_table_core #(
  parameter int unsigned COORD_BITS = dmct_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dmct_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               command_i,
  input  logic [dmct_pkg::COORD_W-1:0]       from_x_i,
  input  logic [dmct_pkg::COORD_W-1:0]       from_y_i,
  input  logic [dmct_pkg::COORD_W-1:0]       to_x_i,
  input  logic [dmct_pkg::COORD_W-1:0]       to_y_i,
  output logic                               done_o,
  output logic signed [dmct_pkg::COST_W-1:0] cost_o,
  output logic                               reachable_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dmct_pkg::APB_AW-1:0]        paddr,
  input  logic [dmct_pkg::APB_DW-1:0]        pwdata,
  output logic [dmct_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  logic [dmct_pkg::OLD_W-1:0] old_weight;
  logic [dmct_pkg::MIS_W-1:0] mismatch_weight;
  dmct_pkg::dp_cmd_t          dp_cmd;
  dmct_pkg::dp_sts_t          dp_sts;

  // Configuration registers.
  dmct_regs u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .old_weight_o      (old_weight),
    .mismatch_weight_o (mismatch_weight)
  );

  // Sequencing.
  dmct_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (dp_sts),
    .cmd_o  (dp_cmd)
  );

  // Table and arithmetic.
  dmct_dpath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .command_i         (command_i),
    .from_x_i          (from_x_i),
    .from_y_i          (from_y_i),
    .to_x_i            (to_x_i),
    .to_y_i            (to_y_i),
    .old_weight_i      (old_weight),
    .mismatch_weight_i (mismatch_weight),
    .cmd_i             (dp_cmd),
    .sts_o             (dp_sts),
    .cost_o            (cost_o),
    .reachable_o       (reachable_o),
    .done_o            (done_o)
  );

endmodule

// ===== dv/direction_map_cost_checker.sv =====
// Checker for the direction map cost table: predicts every move cost and compares it.
module direction_map_cost_checker
  import dmct_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic                     command_i,
  input  logic [COORD_W-1:0]       from_x_i,
  input  logic [COORD_W-1:0]       from_y_i,
  input  logic [COORD_W-1:0]       to_x_i,
  input  logic [COORD_W-1:0]       to_y_i,
  input  logic                     done_i,
  input  logic signed [COST_W-1:0] cost_i,
  input  logic                     reachable_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic [APB_AW-1:0]        paddr_i,
  input  logic [APB_DW-1:0]        pwdata_i,
  input  logic                     pready_i,
  output int unsigned              costs_due_o,
  output int unsigned              fail_count_o
);

  localparam int unsigned GRID_CELLS = 1 << (2 * COORD_BITS_DEF);
  localparam int unsigned FRAC       = FRAC_BITS_DEF;
  localparam longint      UNIT_Q     = longint'(1) << FRAC;
  // Diagonal step length, sqrt(2) rounded to nearest at the cost precision.
  localparam longint      DIAG_STEP  =
    longint'((ROOT2_Q52 + (64'd1 << (51 - FRAC))) >> (52 - FRAC));
  localparam longint      COST_HI    = (longint'(1) << (COST_W - 1)) - 1;
  localparam longint      COST_LO    = -(longint'(1) << (COST_W - 1));

  typedef logic signed [FRAC+1:0] heading_t;

  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic                     reachable;
  } move_cost_t;

  // Predicted table contents and register copies.
  heading_t       heading_x [GRID_CELLS];
  heading_t       heading_y [GRID_CELLS];
  bit             visited   [GRID_CELLS];
  logic [OLD_W-1:0] keep_share;
  logic [MIS_W-1:0] penalty_scale;
  move_cost_t     costs_due [$];

  initial fail_count_o = 0;
  initial costs_due_o  = 0;

  // Round a scaled value back by s bits, to nearest with ties away from zero.
  function automatic longint round_away(longint v, int unsigned s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic int step_sign(int d);
    if (d > 0) return 1;
    if (d < 0) return -1;
    return 0;
  endfunction

  // Blend one component of a stored heading toward a unit step.
  function automatic heading_t blend_component(heading_t kept, int step);
    longint w_keep;
    longint w_new;
    w_keep = (keep_share > KEEP_FULL) ? longint'(KEEP_FULL) : longint'(keep_share);
    w_new  = 256 - w_keep;
    return heading_t'(round_away(w_keep * longint'(kept) + w_new * step * UNIT_Q, 8));
  endfunction

  // Store the step direction into one cell, or blend it into a visited one.
  function automatic void merge_heading(int idx, int sx, int sy);
    if (!visited[idx]) begin
      heading_x[idx] = heading_t'(sx * UNIT_Q);
      heading_y[idx] = heading_t'(sy * UNIT_Q);
      visited[idx]   = 1'b1;
    end else begin
      heading_x[idx] = blend_component(heading_x[idx], sx);
      heading_y[idx] = blend_component(heading_y[idx], sy);
    end
  endfunction

  // Disagreement of a visited cell's heading with the step, 1 - dot product.
  function automatic longint heading_penalty(int idx, int sx, int sy);
    if (!visited[idx]) return 0;
    return UNIT_Q - (longint'(heading_x[idx]) * sx + longint'(heading_y[idx]) * sy);
  endfunction

  function automatic move_cost_t price_move(int fx, int fy, int tx, int ty);
    move_cost_t res;
    int         sx;
    int         sy;
    longint     h;
    longint     acc;
    longint     total;
    sx = step_sign(tx - fx);
    sy = step_sign(ty - fy);
    res.cost      = '0;
    res.reachable = 1'b0;
    // Cells farther apart than one step cannot be reached in one move.
    if (tx - fx > 1 || tx - fx < -1 || ty - fy > 1 || ty - fy < -1) return res;
    if (sx != 0 && sy != 0) h = DIAG_STEP;
    else if (sx != 0 || sy != 0) h = UNIT_Q;
    else h = 0;
    acc   = heading_penalty((fy << COORD_W) | fx, sx, sy) +
            heading_penalty((ty << COORD_W) | tx, sx, sy);
    total = h + round_away(longint'(penalty_scale) * acc, 10);
    if (total > COST_HI) total = COST_HI;
    if (total < COST_LO) total = COST_LO;
    res.cost      = total[COST_W-1:0];
    res.reachable = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    move_cost_t want;
    int         fx;
    int         fy;
    int         tx;
    int         ty;
    reg_e       which;
    if (!rst_ni) begin
      visited       = '{default: 1'b0};
      keep_share    = OLD_WEIGHT_RST;
      penalty_scale = MIS_WEIGHT_RST;
      costs_due.delete();
    end else begin
      // Register write transfer.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        which = reg_e'(paddr_i >> 2);
        if (which == REG_OLD_WEIGHT) keep_share = pwdata_i[OLD_W-1:0];
        else penalty_scale = pwdata_i[MIS_W-1:0];
      end

      // Result strobe: compare against the oldest pending query.
      if (done_i === 1'b1) begin
        if (costs_due.size() == 0) begin
          $error("result with no query pending: cost %0d reachable %0b",
                 cost_i, reachable_i);
          fail_count_o++;
        end else begin
          want = costs_due.pop_front();
          if (cost_i !== want.cost) begin
            $error("cost: expected %0d, actual %0d", want.cost, cost_i);
            fail_count_o++;
          end
          if (reachable_i !== want.reachable) begin
            $error("reachable: expected %0b, actual %0b", want.reachable, reachable_i);
            fail_count_o++;
          end
        end
      end

      // Item transfer: records update the table, queries queue a cost.
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        fx = int'(from_x_i);
        fy = int'(from_y_i);
        tx = int'(to_x_i);
        ty = int'(to_y_i);
        if (cmd_e'(command_i) == CMD_RECORD) begin
          if (fx != tx || fy != ty) begin
            merge_heading((ty << COORD_W) | tx, step_sign(tx - fx), step_sign(ty - fy));
            merge_heading((fy << COORD_W) | fx, step_sign(tx - fx), step_sign(ty - fy));
          end
        end else begin
          costs_due.push_back(price_move(fx, fy, tx, ty));
        end
      end
    end
    costs_due_o = costs_due.size();
  end

endmodule

// ===== dv/tb_direction_map_cost_table_core.sv =====
// Testbench top for the direction map cost table: clock, reset, stimulus and verdict.
module tb_direction_map_cost_table_core;
  import dmct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 155;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     command_i = 1'b0;
  logic [COORD_W-1:0]       from_x_i = '0;
  logic [COORD_W-1:0]       from_y_i = '0;
  logic [COORD_W-1:0]       to_x_i = '0;
  logic [COORD_W-1:0]       to_y_i = '0;
  logic                     done_o;
  logic signed [COST_W-1:0] cost_o;
  logic                     reachable_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  int unsigned              costs_due;
  int unsigned              fail_count;
  int unsigned              cycles = 0;
  logic [COORD_W-1:0]       base_x = '0;
  logic [COORD_W-1:0]       base_y = '0;

  always #4 clk_i = ~clk_i;

  direction_map_cost_table_core dut (
    .clk_i, .rst_ni, .start, .busy, .command_i,
    .from_x_i, .from_y_i, .to_x_i, .to_y_i,
    .done_o, .cost_o, .reachable_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  direction_map_cost_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i,
    .from_x_i, .from_y_i, .to_x_i, .to_y_i,
    .done_i(done_o), .cost_i(cost_o), .reachable_i(reachable_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .costs_due_o(costs_due), .fail_count_o(fail_count)
  );

  // Watchdog: the clearing pass after reset is included in the limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one item and hold it until its transfer edge.
  task automatic send_move(cmd_e cmd, logic [7:0] fx, logic [7:0] fy,
                           logic [7:0] tx, logic [7:0] ty);
    start     <= 1'b1;
    command_i <= cmd;
    from_x_i  <= fx;
    from_y_i  <= fy;
    to_x_i    <= tx;
    to_y_i    <= ty;
    @(negedge clk_i);
    while (busy !== 1'b0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // With the given chance in percent, drop start and wait a random while.
  task automatic sender_pause(int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Hold off until every queued cost has come back and the block is free.
  task automatic drain_costs();
    start <= 1'b0;
    @(negedge clk_i);
    while (costs_due != 0 || busy !== 1'b0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(reg_e which, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (pready !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write both weights with random junk in the unused upper bits.
  task automatic set_weights(logic [OLD_W-1:0] keep, logic [MIS_W-1:0] scale);
    write_reg(REG_OLD_WEIGHT, ($urandom & ~32'h1FF) | 32'(keep));
    write_reg(REG_MISMATCH_WEIGHT, ($urandom & ~32'hFFFF) | 32'(scale));
  endtask

  // Moves mostly between neighbors in a small window so cells get revisited.
  task automatic random_move();
    cmd_e        cmd;
    logic [7:0]  fx;
    logic [7:0]  fy;
    logic [7:0]  tx;
    logic [7:0]  ty;
    int unsigned pick;
    if ($urandom_range(39) == 0) begin
      case ($urandom_range(9))
        0:       base_x = 8'd0;
        1:       base_x = 8'd252;
        default: base_x = 8'($urandom);
      endcase
      case ($urandom_range(9))
        0:       base_y = 8'd252;
        1:       base_y = 8'd0;
        default: base_y = 8'($urandom);
      endcase
    end
    cmd  = ($urandom_range(99) < 55) ? CMD_RECORD : CMD_QUERY;
    fx   = base_x + 8'($urandom_range(5));
    fy   = base_y + 8'($urandom_range(5));
    pick = $urandom_range(99);
    if (pick < 80) begin
      tx = fx + 8'($urandom_range(2)) - 8'd1;
      ty = fy + 8'($urandom_range(2)) - 8'd1;
    end else if (pick < 88) begin
      tx = fx;
      ty = fy;
    end else begin
      tx = 8'($urandom);
      ty = 8'($urandom);
    end
    send_move(cmd, fx, fy, tx, ty);
  endtask

  initial begin
    int unsigned idle_pct;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_weights(OLD_WEIGHT_RST, MIS_WEIGHT_RST);

    // Directed moves: unseen, blended, equal, distant and edge-of-grid cells.
    send_move(CMD_QUERY,  8'd0,   8'd0,   8'd0,   8'd0);
    send_move(CMD_QUERY,  8'd0,   8'd0,   8'd1,   8'd0);
    send_move(CMD_QUERY,  8'd255, 8'd255, 8'd254, 8'd254);
    send_move(CMD_QUERY,  8'd0,   8'd0,   8'd255, 8'd255);
    send_move(CMD_QUERY,  8'd0,   8'd0,   8'd2,   8'd0);
    send_move(CMD_RECORD, 8'd10,  8'd10,  8'd11,  8'd11);
    send_move(CMD_RECORD, 8'd10,  8'd10,  8'd11,  8'd11);
    send_move(CMD_RECORD, 8'd11,  8'd11,  8'd10,  8'd10);
    send_move(CMD_QUERY,  8'd10,  8'd10,  8'd11,  8'd11);
    send_move(CMD_QUERY,  8'd11,  8'd11,  8'd10,  8'd10);
    send_move(CMD_QUERY,  8'd10,  8'd11,  8'd11,  8'd10);
    send_move(CMD_QUERY,  8'd10,  8'd10,  8'd10,  8'd11);
    send_move(CMD_QUERY,  8'd10,  8'd10,  8'd10,  8'd10);
    send_move(CMD_RECORD, 8'd10,  8'd10,  8'd10,  8'd10);
    send_move(CMD_QUERY,  8'd10,  8'd10,  8'd10,  8'd10);
    send_move(CMD_RECORD, 8'd0,   8'd255, 8'd255, 8'd0);
    send_move(CMD_QUERY,  8'd0,   8'd255, 8'd1,   8'd254);
    send_move(CMD_RECORD, 8'd255, 8'd0,   8'd254, 8'd1);
    send_move(CMD_QUERY,  8'd255, 8'd0,   8'd254, 8'd0);
    send_move(CMD_RECORD, 8'd128, 8'd127, 8'd127, 8'd128);
    send_move(CMD_QUERY,  8'd127, 8'd128, 8'd128, 8'd127);
    send_move(CMD_QUERY,  8'd128, 8'd127, 8'd128, 8'd128);

    // Random phases, each with its own weights and sender idling.
    for (int unsigned p = 0; p < PHASES; p++) begin
      drain_costs();
      repeat (8) @(posedge clk_i);
      case (p)
        0: begin set_weights(9'd0, 16'hFFFF); idle_pct = 0; end
        1: begin set_weights(KEEP_FULL, 16'd0); idle_pct = 52; end
        2: begin set_weights(9'd511, 16'd1); idle_pct = 15; end
        3: begin set_weights(9'($urandom), 16'($urandom)); idle_pct = 0; end
        4: begin set_weights(9'd128, 16'hFFFF); idle_pct = 52; end
        default: begin set_weights(9'($urandom), 16'($urandom)); idle_pct = 15; end
      endcase
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 60) drain_costs();
        sender_pause(idle_pct);
        random_move();
      end
    end

    drain_costs();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/dmct_pkg.sv
src/dmct_regs.sv
src/dmct_ctrl.sv
src/dmct_dpath.sv
src/direction_map_cost_table_core.sv
dv/direction_map_cost_checker.sv
dv/tb_direction_map_cost_table_core.sv
